### hdl/t16add_pkg.sv
// Shared types and constants for the Thumb-16 ADD execute unit.
// Used by the decoder, the register memory and the top level; no dependencies.
`default_nettype none

package t16add_pkg;

   localparam int unsigned REG_W  = 32;
   localparam int unsigned IDX_W  = 4;
   localparam int unsigned IMM_W  = 10;
   localparam int unsigned NREGS  = 16;

   localparam logic [1:0] ACT_EXEC = 2'd0;
   localparam logic [1:0] ACT_LOAD = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam logic [IDX_W-1:0] SP_IDX = 4'hD;
   localparam logic [IDX_W-1:0] PC_IDX = 4'hF;

   // opcode prefixes, compared against the top bits of the halfword
   localparam logic [6:0] OPC_ADD_IMM_T1    = 7'b0001110;
   localparam logic [6:0] OPC_ADD_REG_T1    = 7'b0001100;
   localparam logic [4:0] OPC_ADD_IMM_T2    = 5'b00110;
   localparam logic [4:0] OPC_ADD_SP_IMM_T1 = 5'b10101;
   localparam logic [8:0] OPC_ADD_SP_IMM_T2 = 9'b101100000;
   localparam logic [7:0] OPC_ADD_HI        = 8'h44;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOAD,
      OP_READ,
      OP_ADD
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   dest;
      logic [IDX_W-1:0]   addr_a;
      logic [IDX_W-1:0]   addr_b;
      logic               b_is_imm;
      logic [IMM_W-1:0]   imm;
      logic               set_flags;
   } ctl_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

endpackage

`default_nettype wire

### hdl/t16add_decode.sv
// Decoder for the 16-bit Thumb ADD encodings and the register access actions.
// Depends on t16add_pkg; purely combinational.
`default_nettype none

module t16add_decode
   import t16add_pkg::*;
(
   input  wire logic [1:0]        action,
   input  wire logic [15:0]       instruction,
   input  wire logic [IDX_W-1:0]  reg_index,
   output ctl_type                ctl
);

   logic [IDX_W-1:0] m4;
   logic [IDX_W-1:0] d4;

   assign m4 = instruction[6:3];
   assign d4 = {instruction[7], instruction[2:0]};

   always_comb begin
      ctl           = '0;
      ctl.op        = OP_NONE;
      case (action)
         ACT_LOAD: begin
            ctl.op   = OP_LOAD;
            ctl.dest = reg_index;
         end
         ACT_READ: begin
            ctl.op     = OP_READ;
            ctl.dest   = reg_index;
            ctl.addr_a = reg_index;
         end
         ACT_EXEC: begin
            if (instruction[15:9] == OPC_ADD_IMM_T1) begin
               ctl.op        = OP_ADD;
               ctl.dest      = {1'b0, instruction[2:0]};
               ctl.addr_a    = {1'b0, instruction[5:3]};
               ctl.b_is_imm  = 1'b1;
               ctl.imm       = {7'd0, instruction[8:6]};
               ctl.set_flags = 1'b1;
            end else if (instruction[15:9] == OPC_ADD_REG_T1) begin
               ctl.op        = OP_ADD;
               ctl.dest      = {1'b0, instruction[2:0]};
               ctl.addr_a    = {1'b0, instruction[5:3]};
               ctl.addr_b    = {1'b0, instruction[8:6]};
               ctl.set_flags = 1'b1;
            end else if (instruction[15:11] == OPC_ADD_IMM_T2) begin
               ctl.op        = OP_ADD;
               ctl.dest      = {1'b0, instruction[10:8]};
               ctl.addr_a    = {1'b0, instruction[10:8]};
               ctl.b_is_imm  = 1'b1;
               ctl.imm       = {2'd0, instruction[7:0]};
               ctl.set_flags = 1'b1;
            end else if (instruction[15:11] == OPC_ADD_SP_IMM_T1) begin
               ctl.op       = OP_ADD;
               ctl.dest     = {1'b0, instruction[10:8]};
               ctl.addr_a   = SP_IDX;
               ctl.b_is_imm = 1'b1;
               ctl.imm      = {instruction[7:0], 2'b00};
            end else if (instruction[15:7] == OPC_ADD_SP_IMM_T2) begin
               ctl.op       = OP_ADD;
               ctl.dest     = SP_IDX;
               ctl.addr_a   = SP_IDX;
               ctl.b_is_imm = 1'b1;
               ctl.imm      = {1'b0, instruction[6:0], 2'b00};
            end else if (instruction[15:8] == OPC_ADD_HI) begin
               ctl.op = OP_ADD;
               if (m4 == SP_IDX) begin
                  // SP reg T1 wins over T2 when both fields name SP
                  ctl.dest   = d4;
                  ctl.addr_a = SP_IDX;
                  ctl.addr_b = d4;
               end else if (d4 == SP_IDX) begin
                  ctl.dest   = SP_IDX;
                  ctl.addr_a = SP_IDX;
                  ctl.addr_b = m4;
               end else begin
                  ctl.dest   = d4;
                  ctl.addr_a = d4;
                  ctl.addr_b = m4;
               end
            end
         end
         default: begin
            ctl.op = OP_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hdl/t16add_regfile.sv
// Register memory: 16 x 32, one write port, two registered read ports.
// Valid bits give the all-zero reset; a same-edge write is forwarded to the reads.
// Depends on t16add_pkg.
`default_nettype none

module t16add_regfile
   import t16add_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [IDX_W-1:0]  rd_addr_a,
   input  wire logic [IDX_W-1:0]  rd_addr_b,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_addr,
   input  wire logic [REG_W-1:0]  wr_data,
   output logic      [REG_W-1:0]  rd_data_a,
   output logic      [REG_W-1:0]  rd_data_b
);

   logic [REG_W-1:0] mem [NREGS];
   logic [NREGS-1:0] vld_ff;
   logic [REG_W-1:0] rd_a_ff, rd_b_ff;
   logic             vld_a_ff, vld_b_ff;
   logic             hit_a_ff, hit_b_ff;
   logic [REG_W-1:0] fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
         fwd_ff  <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         hit_a_ff <= 1'b0;
         hit_b_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            vld_a_ff <= vld_ff[rd_addr_a];
            vld_b_ff <= vld_ff[rd_addr_b];
            hit_a_ff <= wr_en && (wr_addr == rd_addr_a);
            hit_b_ff <= wr_en && (wr_addr == rd_addr_b);
         end
      end
   end

   assign rd_data_a = hit_a_ff ? fwd_ff : (vld_a_ff ? rd_a_ff : '0);
   assign rd_data_b = hit_b_ff ? fwd_ff : (vld_b_ff ? rd_b_ff : '0);

endmodule

`default_nettype wire

### hdl/thumb16_add_execute_unit.sv
// Thumb-16 ADD execute unit: top level with decode, execute and result register.
// Depends on t16add_pkg, t16add_decode and t16add_regfile.
//
// Sustains one beat per cycle while rsp_ready keeps the result register free. A request
// is decoded and its operands are read from the register memory in the cycle it is
// accepted; the execute stage then adds, writes back and loads the result register
// once that register is free. The rate is set by the single write port and the
// adder; a write is forwarded to a read of the same register issued on
// the same edge. Reset clears the register file through per-entry valid bits
// at once, with no clearing pass. Unrecognized halfwords change nothing.
`default_nettype none

module thumb16_add_execute_unit
   import t16add_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_action,
   input  wire logic [15:0]       req_instruction,
   input  wire logic [IDX_W-1:0]  req_reg_index,
   input  wire logic [REG_W-1:0]  req_reg_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_recognized,
   output logic      [IDX_W-1:0]  rsp_dest_index,
   output logic      [REG_W-1:0]  rsp_value,
   output logic                   rsp_pc_written,
   output logic                   rsp_flag_n,
   output logic                   rsp_flag_z,
   output logic                   rsp_flag_c,
   output logic                   rsp_flag_v
);

   ctl_type          dec_ctl;
   ctl_type          ctl_ff;
   logic [REG_W-1:0] load_ff;
   logic             s1_valid_ff;
   logic             s1_adv;
   logic             req_fire;

   logic [REG_W-1:0] opa, opb, regb;
   logic [REG_W:0]   sum;
   logic [REG_W-1:0] value_in;
   logic             pcw_in;
   flags_type        flags_ff, flags_in, add_flags;
   logic             wr_en;

   logic             rsp_valid_ff;
   logic             rec_ff, pcw_ff;
   logic [IDX_W-1:0] dest_ff;
   logic [REG_W-1:0] value_ff;
   flags_type        rsp_flags_ff;

   t16add_decode u_decode (
      .action      (req_action),
      .instruction (req_instruction),
      .reg_index   (req_reg_index),
      .ctl         (dec_ctl)
   );

   t16add_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_addr_a (dec_ctl.addr_a),
      .rd_addr_b (dec_ctl.addr_b),
      .wr_en     (wr_en),
      .wr_addr   (ctl_ff.dest),
      .wr_data   (value_in),
      .rd_data_a (opa),
      .rd_data_b (regb)
   );

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   // execute
   assign opb = ctl_ff.b_is_imm ? {{(REG_W-IMM_W){1'b0}}, ctl_ff.imm} : regb;
   assign sum = {1'b0, opa} + {1'b0, opb};

   always_comb begin
      add_flags.n = sum[REG_W-1];
      add_flags.z = (sum[REG_W-1:0] == '0);
      add_flags.c = sum[REG_W];
      add_flags.v = (opa[REG_W-1] == opb[REG_W-1]) && (sum[REG_W-1] != opa[REG_W-1]);
   end

   always_comb begin
      value_in = '0;
      pcw_in   = 1'b0;
      flags_in = flags_ff;
      case (ctl_ff.op)
         OP_LOAD: value_in = load_ff;
         OP_READ: value_in = opa;
         OP_ADD: begin
            value_in = sum[REG_W-1:0];
            if (ctl_ff.dest == PC_IDX) begin
               value_in[0] = 1'b0;
               pcw_in      = 1'b1;
            end
            if (ctl_ff.set_flags) begin
               flags_in = add_flags;
            end
         end
         default: value_in = '0;
      endcase
   end

   assign wr_en = s1_adv && ((ctl_ff.op == OP_LOAD) || (ctl_ff.op == OP_ADD));

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ctl_ff  <= dec_ctl;
         load_ff <= req_reg_value;
      end
      if (s1_adv) begin
         rec_ff       <= (ctl_ff.op != OP_NONE);
         dest_ff      <= ctl_ff.dest;
         value_ff     <= value_in;
         pcw_ff       <= pcw_in;
         rsp_flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            flags_ff     <= flags_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_recognized = rec_ff;
   assign rsp_dest_index = dest_ff;
   assign rsp_value      = value_ff;
   assign rsp_pc_written = pcw_ff;
   assign rsp_flag_n     = rsp_flags_ff.n;
   assign rsp_flag_z     = rsp_flags_ff.z;
   assign rsp_flag_c     = rsp_flags_ff.c;
   assign rsp_flag_v     = rsp_flags_ff.v;

`ifndef NO_ASSERTIONS
   a_wr_needs_item: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> s1_valid_ff)
      else $error("register write without an item in execute");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> !req_ready)
      else $error("request taken while execute stage is stalled");

   a_pc_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pc_written) |->
         (rsp_recognized && (rsp_dest_index == PC_IDX) && !rsp_value[0]))
      else $error("bad PC write beat");

   a_unrec_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_recognized) |->
         ((rsp_dest_index == '0) && (rsp_value == '0) && !rsp_pc_written))
      else $error("unrecognized beat carries nonzero payload");

   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !(s1_adv && (ctl_ff.op == OP_ADD) && ctl_ff.set_flags) |=> $stable(flags_ff))
      else $error("flags changed without a flag-setting add");
`endif

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for thumb16_add_execute_unit: directed and random beats,
// predicted in-line and compared on every result beat.
// Depends on t16add_pkg and the thumb16_add_execute_unit RTL.
`default_nettype none

module testbench
   import t16add_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned MAX_REPORTS = 10;

   typedef struct packed {
      logic             recognized;
      logic [IDX_W-1:0] dest;
      logic [REG_W-1:0] value;
      logic             pc_written;
      logic             n;
      logic             z;
      logic             c;
      logic             v;
   } add_outcome_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_action;
   logic [15:0]          req_instruction;
   logic [IDX_W-1:0]     req_reg_index;
   logic [REG_W-1:0]     req_reg_value;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_recognized;
   logic [IDX_W-1:0]     rsp_dest_index;
   logic [REG_W-1:0]     rsp_value;
   logic                 rsp_pc_written;
   logic                 rsp_flag_n;
   logic                 rsp_flag_z;
   logic                 rsp_flag_c;
   logic                 rsp_flag_v;

   // shadow architectural state
   logic [REG_W-1:0]     arch_regs [NREGS];
   flags_type            arch_flags;

   add_outcome_type      pending_outcomes [$];
   int unsigned          mismatch_count;
   int unsigned          idle_cycles;
   int unsigned          send_idle_pct;
   int unsigned          recv_stall_pct;
   int unsigned          hold_request;
   int unsigned          hold_left;

   thumb16_add_execute_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_instruction (req_instruction),
      .req_reg_index   (req_reg_index),
      .req_reg_value   (req_reg_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_recognized  (rsp_recognized),
      .rsp_dest_index  (rsp_dest_index),
      .rsp_value       (rsp_value),
      .rsp_pc_written  (rsp_pc_written),
      .rsp_flag_n      (rsp_flag_n),
      .rsp_flag_z      (rsp_flag_z),
      .rsp_flag_c      (rsp_flag_c),
      .rsp_flag_v      (rsp_flag_v)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one beat to the shadow state and returns the result it should produce.
   function automatic add_outcome_type execute_add_beat(logic [1:0] act, logic [15:0] ins,
                                                        logic [IDX_W-1:0] idx,
                                                        logic [REG_W-1:0] rv);
      add_outcome_type  o;
      logic [IDX_W-1:0] dst, m4, d4;
      logic [REG_W-1:0] a, b, sum;
      logic             wr, setf;
      o = '0;
      dst = '0;
      a = '0;
      b = '0;
      wr = 1'b0;
      setf = 1'b0;
      case (act)
         ACT_LOAD: begin
            arch_regs[idx] = rv;
            o.recognized = 1'b1;
            o.dest = idx;
            o.value = rv;
         end
         ACT_READ: begin
            o.recognized = 1'b1;
            o.dest = idx;
            o.value = arch_regs[idx];
         end
         ACT_EXEC: begin
            if (ins[15:9] == OPC_ADD_IMM_T1) begin
               dst = {1'b0, ins[2:0]};
               a = arch_regs[{1'b0, ins[5:3]}];
               b = {29'd0, ins[8:6]};
               setf = 1'b1;
               wr = 1'b1;
            end else if (ins[15:9] == OPC_ADD_REG_T1) begin
               dst = {1'b0, ins[2:0]};
               a = arch_regs[{1'b0, ins[5:3]}];
               b = arch_regs[{1'b0, ins[8:6]}];
               setf = 1'b1;
               wr = 1'b1;
            end else if (ins[15:11] == OPC_ADD_IMM_T2) begin
               dst = {1'b0, ins[10:8]};
               a = arch_regs[dst];
               b = {24'd0, ins[7:0]};
               setf = 1'b1;
               wr = 1'b1;
            end else if (ins[15:11] == OPC_ADD_SP_IMM_T1) begin
               dst = {1'b0, ins[10:8]};
               a = arch_regs[SP_IDX];
               b = {22'd0, ins[7:0], 2'b00};
               wr = 1'b1;
            end else if (ins[15:7] == OPC_ADD_SP_IMM_T2) begin
               dst = SP_IDX;
               a = arch_regs[SP_IDX];
               b = {23'd0, ins[6:0], 2'b00};
               wr = 1'b1;
            end else if (ins[15:8] == OPC_ADD_HI) begin
               m4 = ins[6:3];
               d4 = {ins[7], ins[2:0]};
               // Rm of SP wins over Rdn of SP when both fields name it
               if (m4 == SP_IDX) begin
                  dst = d4;
                  a = arch_regs[SP_IDX];
                  b = arch_regs[d4];
               end else if (d4 == SP_IDX) begin
                  dst = SP_IDX;
                  a = arch_regs[SP_IDX];
                  b = arch_regs[m4];
               end else begin
                  dst = d4;
                  a = arch_regs[d4];
                  b = arch_regs[m4];
               end
               wr = 1'b1;
            end
            if (wr) begin
               sum = a + b;
               if (setf) begin
                  arch_flags.n = sum[REG_W-1];
                  arch_flags.z = (sum == '0);
                  arch_flags.c = (sum < a);
                  arch_flags.v = (a[REG_W-1] ^ sum[REG_W-1]) & (b[REG_W-1] ^ sum[REG_W-1]);
               end
               o.recognized = 1'b1;
               if (dst == PC_IDX) begin
                  sum[0] = 1'b0;
                  o.pc_written = 1'b1;
               end
               arch_regs[dst] = sum;
               o.dest = dst;
               o.value = sum;
            end
         end
         default: ;
      endcase
      o.n = arch_flags.n;
      o.z = arch_flags.z;
      o.c = arch_flags.c;
      o.v = arch_flags.v;
      return o;
   endfunction

   // Predict on input beats, then compare result beats against the oldest prediction.
   always @(posedge clock) begin
      add_outcome_type want;
      logic            bad;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_outcomes.push_back(execute_add_beat(req_action, req_instruction,
                                                        req_reg_index, req_reg_value));
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: result beat with nothing expected: dest %0d value %h",
                           $realtime, rsp_dest_index, rsp_value);
            end else begin
               want = pending_outcomes.pop_front();
               bad = (want.recognized !== rsp_recognized) ||
                     (want.dest       !== rsp_dest_index) ||
                     (want.value      !== rsp_value)      ||
                     (want.pc_written !== rsp_pc_written) ||
                     (want.n          !== rsp_flag_n)     ||
                     (want.z          !== rsp_flag_z)     ||
                     (want.c          !== rsp_flag_c)     ||
                     (want.v          !== rsp_flag_v);
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $write("%0t: mismatch exp rec %b dest %0d val %h pcw %b nzcv %b%b%b%b",
                            $realtime, want.recognized, want.dest, want.value,
                            want.pc_written, want.n, want.z, want.c, want.v);
                     $display(" / got rec %b dest %0d val %h pcw %b nzcv %b%b%b%b",
                              rsp_recognized, rsp_dest_index, rsp_value, rsp_pc_written,
                              rsp_flag_n, rsp_flag_z, rsp_flag_c, rsp_flag_v);
                  end
               end
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   // Drives one beat at the falling edge and returns at the edge that accepts it.
   task automatic send_beat(logic [1:0] act, logic [15:0] ins, logic [IDX_W-1:0] idx,
                            logic [REG_W-1:0] rv);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_instruction <= ins;
      req_reg_index   <= idx;
      req_reg_value   <= rv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [REG_W-1:0] random_word();
      case ($urandom_range(7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return $urandom_range(255);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] random_add_halfword();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(7))
         0:       return {OPC_ADD_IMM_T1, r[8:0]};
         1:       return {OPC_ADD_IMM_T2, r[10:0]};
         2:       return {OPC_ADD_REG_T1, r[8:0]};
         3:       return {OPC_ADD_HI, r[7:0]};
         4:       return {OPC_ADD_SP_IMM_T1, r[10:0]};
         5:       return {OPC_ADD_SP_IMM_T2, r[6:0]};
         6:       return {OPC_ADD_HI, r[0], SP_IDX, r[3:1]};
         default: return {OPC_ADD_HI, SP_IDX[3], r[4:1], SP_IDX[2:0]};
      endcase
   endfunction

   task automatic test_directed_encodings();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_beat(ACT_LOAD, 16'h0000, 4'd0, 32'h0000_0000);
      send_beat(ACT_LOAD, 16'hFFFF, 4'd1, 32'hFFFF_FFFF);
      send_beat(ACT_LOAD, 16'h0000, 4'd2, 32'h8000_0000);
      send_beat(ACT_LOAD, 16'h0000, 4'd3, 32'h7FFF_FFFF);
      send_beat(ACT_LOAD, 16'h0000, SP_IDX, 32'h0000_1000);
      // odd PC load keeps bit 0
      send_beat(ACT_LOAD, 16'h0000, PC_IDX, 32'h0000_1235);
      send_beat(ACT_READ, 16'h0000, PC_IDX, 32'h0);
      send_beat(ACT_EXEC, {OPC_ADD_IMM_T1, 3'd1, 3'd1, 3'd4}, 4'd0, 32'h0);
      send_beat(ACT_EXEC, {OPC_ADD_IMM_T1, 3'd7, 3'd3, 3'd5}, 4'd0, 32'h0);
      send_beat(ACT_EXEC, {OPC_ADD_IMM_T2, 3'd2, 8'hFF}, 4'd0, 32'h0);
      send_beat(ACT_EXEC, {OPC_ADD_REG_T1, 3'd3, 3'd3, 3'd6}, 4'd0, 32'h0);
      send_beat(ACT_EXEC, {OPC_ADD_REG_T1, 3'd0, 3'd0, 3'd7}, 4'd0, 32'h0);
      send_beat(ACT_EXEC, {OPC_ADD_HI, 1'b1, 4'd1, 3'd0}, 4'd0, 32'h0);
      send_beat(ACT_EXEC, {OPC_ADD_HI, 1'b1, 4'd1, 3'd7}, 4'd0, 32'h0);
      // PC + PC
      send_beat(ACT_EXEC, {OPC_ADD_HI, PC_IDX[3], PC_IDX, PC_IDX[2:0]}, 4'd0, 32'h0);
      send_beat(ACT_EXEC, {OPC_ADD_SP_IMM_T1, 3'd0, 8'hFF}, 4'd0, 32'h0);
      send_beat(ACT_EXEC, {OPC_ADD_SP_IMM_T2, 7'h7F}, 4'd0, 32'h0);
      send_beat(ACT_EXEC, {OPC_ADD_HI, 1'b0, SP_IDX, 3'd2}, 4'd0, 32'h0);
      send_beat(ACT_EXEC, {OPC_ADD_HI, 1'b1, SP_IDX, 3'd7}, 4'd0, 32'h0);
      send_beat(ACT_EXEC, {OPC_ADD_HI, SP_IDX[3], 4'd1, SP_IDX[2:0]}, 4'd0, 32'h0);
      // SP in both fields: SP = SP + SP
      send_beat(ACT_EXEC, {OPC_ADD_HI, SP_IDX[3], SP_IDX, SP_IDX[2:0]}, 4'd0, 32'h0);
      send_beat(ACT_EXEC, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
      send_beat(ACT_EXEC, 16'h0000, 4'd0, 32'h0);
      send_beat(ACT_IGNORED, 16'h1C00, 4'd5, 32'h1234_5678);
      send_beat(ACT_READ, 16'h0000, SP_IDX, 32'h0);
   endtask

   task automatic test_random_traffic(int unsigned count, int unsigned send_pct,
                                      int unsigned recv_pct);
      int unsigned sel;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) begin
         sel = $urandom_range(99);
         if (sel < 12)
            send_beat(ACT_LOAD, 16'($urandom), 4'($urandom), random_word());
         else if (sel < 22)
            send_beat(ACT_READ, 16'($urandom), 4'($urandom), $urandom);
         else if (sel < 26)
            send_beat(ACT_IGNORED, 16'($urandom), 4'($urandom), $urandom);
         else if (sel < 34)
            send_beat(ACT_EXEC, 16'($urandom), 4'($urandom), $urandom);
         else
            send_beat(ACT_EXEC, random_add_halfword(), 4'($urandom), $urandom);
      end
   endtask

   // Long receiver hold-off while the sender keeps offering, so the input stalls.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 300;
      repeat (40)
         send_beat(ACT_EXEC, random_add_halfword(), 4'($urandom), $urandom);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_EXEC;
      req_instruction = '0;
      req_reg_index = '0;
      req_reg_value = '0;
      rsp_ready = 1'b0;
      mismatch_count = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 0;
      hold_left = 0;
      arch_flags = '0;
      for (int i = 0; i < NREGS; i++)
         arch_regs[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_encodings();
      wait_results_drained();
      test_random_traffic(260, 0, 0);
      wait_results_drained();
      test_random_traffic(260, 58, 0);
      wait_results_drained();
      test_backpressure();
      wait_results_drained();
      test_random_traffic(260, 0, 58);
      wait_results_drained();
      test_random_traffic(260, 10, 10);
      wait_results_drained();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
